// ===== hw/rtl/cpdt_pkg.sv =====
// shared types and codes for the character pair table
// used by every module of the block; depends on nothing
`default_nettype none

package cpdt_pkg;

	localparam int TABLE_SLOTS_DEF = 64;
	localparam int ENTRY_W         = 6;

	// operation codes
	localparam logic [1:0] FN_LOOKUP = 2'd0;
	localparam logic [1:0] FN_ADD    = 2'd1;
	localparam logic [1:0] FN_REMOVE = 2'd2;
	localparam logic [1:0] FN_CLEAR  = 2'd3;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NOT_FOUND = 3'd1;
	localparam logic [2:0] ST_DEFINED   = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;
	localparam logic [2:0] ST_ZERO_KEY  = 3'd5;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] key_a;
		logic [7:0] key_b;
		logic [7:0] mapped_char;
	} in_item_t;

	typedef struct packed {
		logic [7:0]         found_char;
		logic [2:0]         status;
		logic [ENTRY_W-1:0] entry_count;
		logic               modified;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       scan_start;
		logic       scan;
		logic       shift_start;
		logic       shift_step;
		logic       shift_wr;
		logic       append;
		logic       drop;
		logic       clear;
		logic       res_set;
		logic       res_hit;
		logic [2:0] res_code;
		logic       publish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       key_zero;
		logic       map_zero;
		logic       full;
		logic       empty;
		logic       hit;
		logic       scan_done;
		logic       shift_more;
	} sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cpdt_dp.sv =====
// datapath of the character pair table: entry memory, scan pointer,
// entry count, result and output registers; uses cpdt_pkg
`default_nettype none

module cpdt_dp #(
	parameter int TABLE_SLOTS = cpdt_pkg::TABLE_SLOTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cpdt_pkg::in_item_t req,
	input  wire cpdt_pkg::cmd_t     cmd,
	output cpdt_pkg::sts_t          sts,
	output cpdt_pkg::out_item_t     rsp
);
	import cpdt_pkg::*;

	localparam int CW = $clog2(TABLE_SLOTS);

	typedef struct packed {
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] mapped;
	} entry_t;

	entry_t mem [TABLE_SLOTS];

	logic [1:0]   op_q;
	logic [7:0]   lo_q;
	logic [7:0]   hi_q;
	logic [7:0]   map_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          flag_q;
	logic          flag_d;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] idx_s1;
	logic          vld_s1;
	entry_t        rdata_q;

	logic          we;
	logic [CW-1:0] wr_addr;
	entry_t        wr_data;

	logic [7:0]         res_found_q;
	logic [2:0]         res_code_q;
	logic [ENTRY_W-1:0] res_count_q;
	logic               res_mod_q;
	out_item_t          rsp_q;

	// operand capture, pair held as (smaller, larger)
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req.func;
			lo_q  <= (req.key_a < req.key_b) ? req.key_a : req.key_b;
			hi_q  <= (req.key_a < req.key_b) ? req.key_b : req.key_a;
			map_q <= req.mapped_char;
		end
	end

	always_comb begin
		count_d = count_q;
		flag_d  = flag_q;
		if (cmd.clear) begin
			count_d = '0;
			flag_d  = 1'b1;
		end else if (cmd.append) begin
			count_d = count_q + CW'(1);
			flag_d  = 1'b1;
		end else if (cmd.drop) begin
			count_d = count_q - CW'(1);
			flag_d  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			flag_q  <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			count_q <= count_d;
			flag_q  <= flag_d;
			vld_s1  <= cmd.scan && (ptr_q < count_q);
		end
	end

	// scan and shift pointer; the memory is read at it every cycle
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			ptr_q <= '0;
		end else if (cmd.shift_start) begin
			ptr_q <= idx_s1 + CW'(1);
		end else if (cmd.shift_step || (cmd.scan && (ptr_q < count_q))) begin
			ptr_q <= ptr_q + CW'(1);
		end
	end

	// during a shift the pointer is two ahead of the slot being filled
	always_comb begin
		we      = cmd.shift_wr || cmd.append;
		wr_addr = cmd.shift_wr ? (ptr_q - CW'(2)) : count_q;
		wr_data = cmd.shift_wr ? rdata_q : entry_t'{lo: lo_q, hi: hi_q, mapped: map_q};
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[ptr_q];
		idx_s1  <= ptr_q;
	end

	always_comb begin
		sts.op         = op_q;
		sts.key_zero   = (lo_q == 8'd0);
		sts.map_zero   = (map_q == 8'd0);
		sts.full       = (count_q == CW'(TABLE_SLOTS - 1));
		sts.empty      = (count_q == '0);
		sts.hit        = vld_s1 && (rdata_q.lo == lo_q) && (rdata_q.hi == hi_q);
		sts.scan_done  = !vld_s1 && (ptr_q == count_q);
		sts.shift_more = (ptr_q < count_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_found_q <= cmd.res_hit ? rdata_q.mapped : 8'd0;
			res_code_q  <= cmd.res_code;
			res_count_q <= ENTRY_W'(count_d);
			res_mod_q   <= flag_d;
		end
		if (cmd.publish) begin
			rsp_q.found_char  <= res_found_q;
			rsp_q.status      <= res_code_q;
			rsp_q.entry_count <= res_count_q;
			rsp_q.modified    <= res_mod_q;
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

// ===== hw/rtl/cpdt_ctrl.sv =====
// controller of the character pair table: sequences scan, shift and
// result hand-off; uses cpdt_pkg, drives cpdt_dp through cmd_t
`default_nettype none

module cpdt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	input  wire cpdt_pkg::sts_t sts,
	output cpdt_pkg::cmd_t      cmd
);
	import cpdt_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_SCAN   = 3'd2;
	localparam logic [2:0] S_SH_RD  = 3'd3;
	localparam logic [2:0] S_SH_WR  = 3'd4;
	localparam logic [2:0] S_DONE   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       rsp_vld_q;
	logic       slot_free;

	assign slot_free = !rsp_vld_q || !rsp_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				unique case (sts.op)
					FN_LOOKUP: begin
						if (sts.key_zero) begin
							cmd.res_set  = 1'b1;
							cmd.res_code = ST_ZERO_KEY;
							state_d      = S_DONE;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					FN_ADD: begin
						if (sts.full) begin
							cmd.res_set  = 1'b1;
							cmd.res_code = ST_FULL;
							state_d      = S_DONE;
						end else if (sts.key_zero || sts.map_zero) begin
							cmd.res_set  = 1'b1;
							cmd.res_code = ST_ZERO_KEY;
							state_d      = S_DONE;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					FN_REMOVE: begin
						if (sts.empty) begin
							cmd.res_set  = 1'b1;
							cmd.res_code = ST_EMPTY;
							state_d      = S_DONE;
						end else if (sts.key_zero) begin
							cmd.res_set  = 1'b1;
							cmd.res_code = ST_ZERO_KEY;
							state_d      = S_DONE;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					default: begin
						cmd.clear    = 1'b1;
						cmd.res_set  = 1'b1;
						cmd.res_code = ST_OK;
						state_d      = S_DONE;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.hit) begin
					if (sts.op == FN_REMOVE) begin
						cmd.shift_start = 1'b1;
						state_d         = S_SH_RD;
					end else begin
						cmd.res_set  = 1'b1;
						cmd.res_hit  = (sts.op == FN_LOOKUP);
						cmd.res_code = (sts.op == FN_LOOKUP) ? ST_OK : ST_DEFINED;
						state_d      = S_DONE;
					end
				end else if (sts.scan_done) begin
					// no match anywhere: add appends, the others miss
					cmd.append   = (sts.op == FN_ADD);
					cmd.res_set  = 1'b1;
					cmd.res_code = (sts.op == FN_ADD) ? ST_OK : ST_NOT_FOUND;
					state_d      = S_DONE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			S_SH_RD: begin
				if (sts.shift_more) begin
					cmd.shift_step = 1'b1;
					state_d        = S_SH_WR;
				end else begin
					cmd.drop     = 1'b1;
					cmd.res_set  = 1'b1;
					cmd.res_code = ST_OK;
					state_d      = S_DONE;
				end
			end
			S_SH_WR: begin
				cmd.shift_wr = 1'b1;
				state_d      = S_SH_RD;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.publish = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			rsp_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				rsp_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_vld_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_vld_q;

endmodule

`default_nettype wire

// ===== hw/rtl/character_pair_digraph_table.sv =====
// Character pair table: maps an unordered pair of nonzero characters to a
// result character, with lookup, add, remove and clear operations.
// Channels: req (in_item_t: func, key_a, key_b, mapped_char) and rsp
// (out_item_t: found_char, status, entry_count, modified), both valid/stall;
// an item moves on an edge where valid is high and stall is low.
// One rsp item is produced for every req item, in order.
// Handling after acceptance, with n entries held:
//   refused before the search (zero key, full, empty) and clear: no search
//   lookup or add: the search stops on a hit at entry i, else ends after all n entries
//   remove of entry i: search up to entry i, then every later entry is moved down
// The search reads one entry per cycle through the single read port of the
// entry memory; a remove moves entries with one read and one write each.
// Items are handled one at a time: req_stall is high from acceptance until
// the result has gone into the output register, so the next item is taken on
// the edge after rsp_valid rises at the earliest. A result waiting under
// rsp_stall does not block acceptance of the next item, but that item's
// result is held back until the output register is free.
// Reset empties the table and clears the modified flag; entry contents are
// not cleared, no clearing pass is needed.
// Depends on cpdt_pkg, cpdt_ctrl and cpdt_dp.
`default_nettype none

module character_pair_digraph_table #(
	parameter int TABLE_SLOTS = cpdt_pkg::TABLE_SLOTS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire cpdt_pkg::in_item_t  req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output cpdt_pkg::out_item_t      rsp
);
	import cpdt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	cpdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cpdt_dp #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/cpdt_checker.sv =====
// port-level checks for the character pair table, bound to the top level
// uses cpdt_pkg
`default_nettype none

module cpdt_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_valid,
	input wire logic                req_stall,
	input wire cpdt_pkg::in_item_t  req,
	input wire logic                rsp_valid,
	input wire logic                rsp_stall,
	input wire cpdt_pkg::out_item_t rsp
);
	import cpdt_pkg::*;

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp item changed while stalled");

	// one item at a time: busy right after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("req accepted while previous item still in work");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.found_char != 8'd0) |-> rsp.status == ST_OK)
		else $error("found character with a failing status");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status <= ST_ZERO_KEY)
		else $error("status code out of range");

	// modified never falls once set
	a_modified_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && rsp.modified ##1 rsp_valid |-> rsp.modified)
		else $error("modified flag dropped");

endmodule

bind character_pair_digraph_table cpdt_checker u_cpdt_checker (.*);

`default_nettype wire

// ===== verif/cpdt_result_check.sv =====
// result checker for the character pair table: watches both channels, predicts each result
// and compares it field by field; hands the failure count and open results to the top
// depends on cpdt_pkg
module cpdt_result_check
	import cpdt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	input  wire logic      req_stall,
	input  wire in_item_t  req,
	input  wire logic      rsp_valid,
	input  wire logic      rsp_stall,
	input  wire out_item_t rsp,
	output int             fail_count,
	output int             outstanding
);

	localparam int SLOTS = TABLE_SLOTS_DEF;

	logic [7:0] pair_lo  [SLOTS];
	logic [7:0] pair_hi  [SLOTS];
	logic [7:0] pair_map [SLOTS];
	int         held = 0;
	logic       touched = 1'b0;
	int         errs = 0;
	out_item_t  expected_q [$];
	out_item_t  want_r;

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	// index of the pair, or held when it is absent
	function automatic int find_pair(input logic [7:0] lo, input logic [7:0] hi);
		for (int i = 0; i < held; i++)
			if (pair_lo[i] == lo && pair_hi[i] == hi)
				return i;
		return held;
	endfunction

	function automatic out_item_t apply_op(input in_item_t it);
		logic [7:0] lo;
		logic [7:0] hi;
		int         idx;
		out_item_t  r;
		lo = (it.key_a < it.key_b) ? it.key_a : it.key_b;
		hi = (it.key_a < it.key_b) ? it.key_b : it.key_a;
		r.found_char = 8'h00;
		r.status = ST_OK;
		case (it.func)
			FN_LOOKUP: begin
				if (lo == 8'h00) begin
					r.status = ST_ZERO_KEY;
				end else begin
					idx = find_pair(lo, hi);
					if (idx < held)
						r.found_char = pair_map[idx];
					else
						r.status = ST_NOT_FOUND;
				end
			end
			FN_ADD: begin
				// full is checked before the zero key
				if (held >= SLOTS - 1) begin
					r.status = ST_FULL;
				end else if (lo == 8'h00 || it.mapped_char == 8'h00) begin
					r.status = ST_ZERO_KEY;
				end else if (find_pair(lo, hi) < held) begin
					r.status = ST_DEFINED;
				end else begin
					pair_lo[held] = lo;
					pair_hi[held] = hi;
					pair_map[held] = it.mapped_char;
					held++;
					touched = 1'b1;
				end
			end
			FN_REMOVE: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else if (lo == 8'h00) begin
					r.status = ST_ZERO_KEY;
				end else begin
					idx = find_pair(lo, hi);
					if (idx >= held) begin
						r.status = ST_NOT_FOUND;
					end else begin
						// later entries move down to keep the order
						for (int j = idx; j < held - 1; j++) begin
							pair_lo[j] = pair_lo[j + 1];
							pair_hi[j] = pair_hi[j + 1];
							pair_map[j] = pair_map[j + 1];
						end
						held--;
						touched = 1'b1;
					end
				end
			end
			default: begin
				held = 0;
				touched = 1'b1;
			end
		endcase
		r.entry_count = ENTRY_W'(held);
		r.modified = touched;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			errs++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			touched = 1'b0;
			expected_q.delete();
		end else begin
			// results first: a result on this edge belongs to an older item
			if (rsp_valid && !rsp_stall) begin
				if (expected_q.size() == 0) begin
					errs++;
					$display("%0t: result with nothing expected, expected none, actual %h",
						$time, rsp);
				end else begin
					want_r = expected_q.pop_front();
					check_field("found_char", want_r.found_char, rsp.found_char);
					check_field("status", 8'(want_r.status), 8'(rsp.status));
					check_field("entry_count", 8'(want_r.entry_count), 8'(rsp.entry_count));
					check_field("modified", 8'(want_r.modified), 8'(rsp.modified));
				end
			end
			if (req_valid && !req_stall)
				expected_q.push_back(apply_op(req));
		end
		fail_count <= errs;
		outstanding <= expected_q.size();
	end

endmodule

// ===== verif/testbench.sv =====
// top of the character pair table testbench: clock, reset, item stimulus and verdict
// depends on cpdt_pkg, character_pair_digraph_table and cpdt_result_check
module testbench;
	import cpdt_pkg::*;

	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int PHASE_ITEMS     = 245;
	localparam int FILL_ITEMS      = 90;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	in_item_t  req = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	out_item_t rsp;

	int fail_count;
	int outstanding;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off_req = 1'b0;
	int quiet = 0;

	character_pair_digraph_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	cpdt_result_check result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// receiver: random stall, or a long hold-off when asked
	initial begin
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rsp_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end else begin
				rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	function automatic in_item_t make_item(input logic [1:0] fn, input logic [7:0] ka,
			input logic [7:0] kb, input logic [7:0] mc);
		in_item_t it;
		it.func = fn;
		it.key_a = ka;
		it.key_b = kb;
		it.mapped_char = mc;
		return it;
	endfunction

	// mostly a small key pool so that hits and duplicates are common
	function automatic logic [7:0] pick_key();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return 8'h00;
		if (r < 74)
			return 8'($urandom_range(1, 12));
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic in_item_t rand_item(input int add_pct, input int clear_pct);
		in_item_t it;
		int       r;
		r = $urandom_range(0, 99);
		if (r < clear_pct)
			it.func = FN_CLEAR;
		else if (r < clear_pct + add_pct)
			it.func = FN_ADD;
		else if (r < clear_pct + add_pct + (100 - clear_pct - add_pct) / 2)
			it.func = FN_REMOVE;
		else
			it.func = FN_LOOKUP;
		it.key_a = pick_key();
		it.key_b = pick_key();
		it.mapped_char = ($urandom_range(0, 99) < 3) ? 8'h00 : 8'($urandom_range(0, 255));
		return it;
	endfunction

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic send_item(input in_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	// called at a falling edge, returns at a rising edge with no result open
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input bit with_hold);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		@(negedge clk);
		// fill burst so the full table is reached, then a mixed load
		repeat (FILL_ITEMS) send_item(rand_item(95, 0));
		if (with_hold) begin
			drain();
			hold_off_req = 1'b1;
			@(negedge clk);
			repeat (30) send_item(rand_item(40, 2));
		end
		repeat (PHASE_ITEMS - FILL_ITEMS) send_item(rand_item(40, 2));
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(make_item(FN_LOOKUP, 8'h00, 8'h00, 8'h00));
		send_item(make_item(FN_REMOVE, 8'h05, 8'h07, 8'h00));
		send_item(make_item(FN_LOOKUP, 8'h03, 8'h09, 8'hff));
		send_item(make_item(FN_ADD,    8'h00, 8'h07, 8'h41));
		send_item(make_item(FN_ADD,    8'h07, 8'h03, 8'h00));
		send_item(make_item(FN_ADD,    8'hff, 8'h01, 8'hff));
		// same pair in the other order is already defined
		send_item(make_item(FN_ADD,    8'h01, 8'hff, 8'h12));
		send_item(make_item(FN_LOOKUP, 8'h01, 8'hff, 8'h00));
		send_item(make_item(FN_LOOKUP, 8'hff, 8'h01, 8'h00));
		send_item(make_item(FN_ADD,    8'h80, 8'h80, 8'h01));
		send_item(make_item(FN_ADD,    8'h55, 8'haa, 8'h7e));
		send_item(make_item(FN_LOOKUP, 8'h80, 8'h80, 8'h00));
		send_item(make_item(FN_LOOKUP, 8'h80, 8'h81, 8'h00));
		send_item(make_item(FN_REMOVE, 8'h00, 8'h55, 8'h00));
		send_item(make_item(FN_REMOVE, 8'h10, 8'h20, 8'h00));
		send_item(make_item(FN_REMOVE, 8'h01, 8'hff, 8'h00));
		send_item(make_item(FN_LOOKUP, 8'haa, 8'h55, 8'h00));
		send_item(make_item(FN_LOOKUP, 8'hff, 8'h01, 8'h00));
		send_item(make_item(FN_CLEAR,  8'hff, 8'hff, 8'hff));
		// clear on an empty table still succeeds
		send_item(make_item(FN_CLEAR,  8'h00, 8'h00, 8'h00));
		send_item(make_item(FN_LOOKUP, 8'haa, 8'h55, 8'h00));
		send_item(make_item(FN_REMOVE, 8'haa, 8'h55, 8'h00));
		drain();

		run_phase(0, 0, 1'b1);
		run_phase(72, 0, 1'b0);
		run_phase(0, 72, 1'b0);
		run_phase(27, 27, 1'b0);

		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
